>>> sv/bfca_pkg.sv
package bfca_pkg;

   localparam int NUM_SERVERS_DEF   = 8;
   localparam int CAPACITY_BITS_DEF = 16;

   localparam int SLOT_W   = 3;
   localparam int AMOUNT_W = 16;

   typedef enum logic {
      ACTION_LOAD  = 1'b0,
      ACTION_PLACE = 1'b1
   } action_type;

   typedef enum logic [1:0] {
      STATUS_PLACED  = 2'd0,
      STATUS_NOFIT   = 2'd1,
      STATUS_INVALID = 2'd2,
      STATUS_LOADED  = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_WRITE,
      ST_DONE
   } state_type;

   typedef struct packed {
      action_type          action;
      logic [SLOT_W-1:0]   slot_index;
      logic [AMOUNT_W-1:0] amount;
   } req_type;

   typedef struct packed {
      status_type          status;
      logic [SLOT_W-1:0]   chosen_slot;
      logic [AMOUNT_W-1:0] slack_left;
   } rsp_type;

   // Control from the sequencer to the slack comparison unit.
   typedef struct packed {
      logic clear;
      logic step;
   } fit_ctl_type;

endpackage

>>> sv/bfca_store.sv
module bfca_store
   import bfca_pkg::*;
#(
   parameter int NUM_SERVERS   = NUM_SERVERS_DEF,
   parameter int CAPACITY_BITS = CAPACITY_BITS_DEF,
   localparam int IDX_W = (NUM_SERVERS > 1) ? $clog2(NUM_SERVERS) : 1
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     wr_en,
   input  logic [IDX_W-1:0]         wr_addr,
   input  logic [CAPACITY_BITS-1:0] wr_data,
   input  logic                     rd_en,
   input  logic [IDX_W-1:0]         rd_addr,
   output logic [CAPACITY_BITS-1:0] rd_cap,
   output logic                     rd_present
);

   logic [CAPACITY_BITS-1:0] cap_mem [NUM_SERVERS];
   logic [NUM_SERVERS-1:0]   present_ff;
   logic [CAPACITY_BITS-1:0] rd_cap_ff;
   logic                     rd_present_ff;

   // Capacities need no clearing: a slot is only considered once a load has
   // marked it present, and that load writes its capacity too.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         cap_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_cap_ff <= cap_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         present_ff    <= '0;
         rd_present_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            present_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_present_ff <= present_ff[rd_addr];
         end
      end
   end

   assign rd_cap     = rd_cap_ff;
   assign rd_present = rd_present_ff;

endmodule

>>> sv/bfca_fit.sv
module bfca_fit
   import bfca_pkg::*;
#(
   parameter int NUM_SERVERS   = NUM_SERVERS_DEF,
   parameter int CAPACITY_BITS = CAPACITY_BITS_DEF,
   localparam int IDX_W = (NUM_SERVERS > 1) ? $clog2(NUM_SERVERS) : 1
) (
   input  logic                     clock,
   input  logic                     reset,
   input  fit_ctl_type              ctl,
   input  logic [IDX_W-1:0]         entry_idx,
   input  logic [CAPACITY_BITS-1:0] entry_cap,
   input  logic                     entry_present,
   input  logic [CAPACITY_BITS-1:0] demand,
   output logic                     found,
   output logic [IDX_W-1:0]         best_idx,
   output logic [CAPACITY_BITS-1:0] best_slack
);

   logic                     found_ff, found_in;
   logic [IDX_W-1:0]         best_idx_ff, best_idx_in;
   logic [CAPACITY_BITS-1:0] best_slack_ff, best_slack_in;
   logic [CAPACITY_BITS:0]   diff_wide;
   logic                     fits;
   logic                     better;

   // The borrow of the subtraction tells whether the slot can take the demand.
   assign diff_wide = {1'b0, entry_cap} - {1'b0, demand};
   assign fits      = entry_present && !diff_wide[CAPACITY_BITS];
   // Strictly smaller slack only, so the lowest slot keeps a tie.
   assign better    = fits &&
                      (!found_ff || (diff_wide[CAPACITY_BITS-1:0] < best_slack_ff));

   always_comb begin
      found_in      = found_ff;
      best_idx_in   = best_idx_ff;
      best_slack_in = best_slack_ff;
      priority if (ctl.clear) begin
         found_in      = 1'b0;
         best_idx_in   = '0;
         best_slack_in = '0;
      end else if (ctl.step && better) begin
         found_in      = 1'b1;
         best_idx_in   = entry_idx;
         best_slack_in = diff_wide[CAPACITY_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else begin
         found_ff <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      best_idx_ff   <= best_idx_in;
      best_slack_ff <= best_slack_in;
   end

   assign found      = found_ff;
   assign best_idx   = best_idx_ff;
   assign best_slack = best_slack_ff;

endmodule

>>> sv/best_fit_capacity_allocator.sv
// Channel   Direction  Handshake            Payload
// req_      in         req_valid/req_stall  req_data  (action, slot_index, amount)
// rsp_      out        rsp_valid/rsp_stall  rsp_data  (status, chosen_slot, slack_left)
//
// A load or a zero demand goes from idle straight to the done state, which fills the output register.
// A placement reads one slot a cycle through the single capacity memory read port
// and one comparison unit, then passes through the write and done states.
// A new item can be taken in the same cycle that the result shows in the output register.
// Synchronous reset clears the present flags and the control state at once.
// A stalled result waits in the output register; the block holds req_stall
// only while a result is still to be placed there.
module best_fit_capacity_allocator
   import bfca_pkg::*;
#(
   parameter int NUM_SERVERS   = NUM_SERVERS_DEF,
   parameter int CAPACITY_BITS = CAPACITY_BITS_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int IDX_W = (NUM_SERVERS > 1) ? $clog2(NUM_SERVERS) : 1;
   localparam int CNT_W = $clog2(NUM_SERVERS + 1);

   state_type                state_ff, state_in;
   logic [CNT_W-1:0]         rd_cnt_ff, rd_cnt_in;
   logic                     eval_vld_ff, eval_vld_in;
   logic [IDX_W-1:0]         eval_idx_ff, eval_idx_in;
   logic [CAPACITY_BITS-1:0] demand_ff, demand_in;
   status_type               status_ff, status_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_type                  rsp_data_ff, rsp_data_in;

   logic                     wr_en;
   logic [IDX_W-1:0]         wr_addr;
   logic [CAPACITY_BITS-1:0] wr_data;
   logic                     rd_en;
   logic [CAPACITY_BITS-1:0] rd_cap;
   logic                     rd_present;
   fit_ctl_type              fit_ctl;
   logic                     fit_found;
   logic [IDX_W-1:0]         fit_best_idx;
   logic [CAPACITY_BITS-1:0] fit_best_slack;
   logic [CAPACITY_BITS-1:0] req_amount;
   logic                     slot_ok;

   assign req_amount = CAPACITY_BITS'(req_data.amount);
   assign slot_ok    = ({{(32 - SLOT_W){1'b0}}, req_data.slot_index} < 32'(NUM_SERVERS));

   bfca_store #(
      .NUM_SERVERS   (NUM_SERVERS),
      .CAPACITY_BITS (CAPACITY_BITS)
   ) u_store (
      .clock      (clock),
      .reset      (reset),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .rd_en      (rd_en),
      .rd_addr    (rd_cnt_ff[IDX_W-1:0]),
      .rd_cap     (rd_cap),
      .rd_present (rd_present)
   );

   bfca_fit #(
      .NUM_SERVERS   (NUM_SERVERS),
      .CAPACITY_BITS (CAPACITY_BITS)
   ) u_fit (
      .clock         (clock),
      .reset         (reset),
      .ctl           (fit_ctl),
      .entry_idx     (eval_idx_ff),
      .entry_cap     (rd_cap),
      .entry_present (rd_present),
      .demand        (demand_ff),
      .found         (fit_found),
      .best_idx      (fit_best_idx),
      .best_slack    (fit_best_slack)
   );

   always_comb begin
      state_in     = state_ff;
      rd_cnt_in    = rd_cnt_ff;
      eval_vld_in  = 1'b0;
      eval_idx_in  = eval_idx_ff;
      demand_in    = demand_ff;
      status_in    = status_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      wr_en        = 1'b0;
      wr_addr      = '0;
      wr_data      = '0;
      rd_en        = 1'b0;
      fit_ctl      = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               demand_in = req_amount;
               priority if (req_data.action == ACTION_LOAD) begin
                  // A load beyond the last slot still reports completion.
                  wr_en     = slot_ok;
                  wr_addr   = IDX_W'(req_data.slot_index);
                  wr_data   = req_amount;
                  status_in = STATUS_LOADED;
                  state_in  = ST_DONE;
               end else if (req_amount == '0) begin
                  status_in = STATUS_INVALID;
                  state_in  = ST_DONE;
               end else begin
                  fit_ctl.clear = 1'b1;
                  rd_cnt_in     = '0;
                  state_in      = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            // Read data of the slot addressed last cycle is judged this cycle.
            fit_ctl.step = eval_vld_ff;
            if (rd_cnt_ff != CNT_W'(NUM_SERVERS)) begin
               rd_en       = 1'b1;
               rd_cnt_in   = rd_cnt_ff + 1'b1;
               eval_vld_in = 1'b1;
               eval_idx_in = rd_cnt_ff[IDX_W-1:0];
            end else begin
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            wr_en     = fit_found;
            wr_addr   = fit_best_idx;
            wr_data   = fit_best_slack;
            status_in = fit_found ? STATUS_PLACED : STATUS_NOFIT;
            state_in  = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in       = 1'b1;
               rsp_data_in.status = status_ff;
               if (status_ff == STATUS_PLACED) begin
                  rsp_data_in.chosen_slot = SLOT_W'(fit_best_idx);
                  rsp_data_in.slack_left  = AMOUNT_W'(fit_best_slack);
               end else begin
                  rsp_data_in.chosen_slot = '0;
                  rsp_data_in.slack_left  = '0;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rd_cnt_ff    <= '0;
         eval_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_cnt_ff    <= rd_cnt_in;
         eval_vld_ff  <= eval_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      eval_idx_ff <= eval_idx_in;
      demand_ff   <= demand_in;
      status_ff   <= status_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

>>> sv/bfca_check.sv
module bfca_check
   import bfca_pkg::*;
#(
   parameter int NUM_SERVERS = NUM_SERVERS_DEF
) (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   // One item at a time: a transfer in must be followed by a closed input.
   a_busy_after_transfer: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input not held off after a transfer");

   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_data))
      else $error("stalled request changed or withdrawn");

   a_unplaced_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status != STATUS_PLACED) |->
         (rsp_data.chosen_slot == '0) && (rsp_data.slack_left == '0))
      else $error("slot or slack reported for a result that placed nothing");

   a_slot_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == STATUS_PLACED) |->
         ({{(32 - SLOT_W){1'b0}}, rsp_data.chosen_slot} < 32'(NUM_SERVERS)) ||
         (NUM_SERVERS > (1 << SLOT_W)))
      else $error("placement reported in a slot that does not exist");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed or dropped");

endmodule

bind best_fit_capacity_allocator bfca_check #(.NUM_SERVERS(NUM_SERVERS)) u_check (.*);
